/* hdl/mrtl_pkg.sv */
// ----------------------------------------------------------------------------
// Memory range type lookup package
// Shared types and constants for the range table, the walker and the top.
// ----------------------------------------------------------------------------
`default_nettype none

package mrtl_pkg;

    // Field widths fixed by the interface.
    localparam int ADDR_W      = 52;
    localparam int TYPE_W      = 3;
    localparam int INDEX_W     = 7;
    localparam int PFN_W       = 40;
    localparam int SMALL_SHIFT = 12;
    localparam int LARGE_SHIFT = 21;
    localparam int PAGE_W      = PFN_W + LARGE_SHIFT;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int COUNT_W     = 8;

    // Item operation codes.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_TYPE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_COUNT  = 1'b1;

    // Uncacheable memory type.
    localparam logic [TYPE_W-1:0] TYPE_UC = 3'd0;

    // One stored range.
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] last;
        logic [TYPE_W-1:0] mtype;
        logic              fixed;
    } t_entry;

    // Walker states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

/* hdl/mrtl_in_if.sv */
// ----------------------------------------------------------------------------
// Input channel
// Carries write and lookup items with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrtl_in_if;
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic [mrtl_pkg::INDEX_W-1:0]        entry_index;
    logic [mrtl_pkg::ADDR_W-1:0]         range_base;
    logic [mrtl_pkg::ADDR_W-1:0]         range_end;
    logic [mrtl_pkg::TYPE_W-1:0]         range_type;
    logic                                range_fixed;
    logic [mrtl_pkg::PFN_W-1:0]          page_number;
    logic                                page_is_large;

    modport source (
        output valid, op, entry_index, range_base, range_end, range_type,
               range_fixed, page_number, page_is_large,
        input  ready
    );

    modport sink (
        input  valid, op, entry_index, range_base, range_end, range_type,
               range_fixed, page_number, page_is_large,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/mrtl_out_if.sv */
// ----------------------------------------------------------------------------
// Output channel
// Carries one lookup result per beat with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrtl_out_if;
    logic                         valid;
    logic                         ready;
    logic [mrtl_pkg::TYPE_W-1:0]  resolved_type;
    logic                         large_page_ok;

    modport source (
        output valid, resolved_type, large_page_ok,
        input  ready
    );

    modport sink (
        input  valid, resolved_type, large_page_ok,
        output ready
    );
endinterface

`default_nettype wire

/* hdl/mrtl_table.sv */
// ----------------------------------------------------------------------------
// Range table memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mrtl_table #(
    parameter int DEPTH = 128,
    parameter int IW    = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [IW-1:0]    i_waddr,
    input  wire mrtl_pkg::t_entry i_wdata,
    input  wire logic [IW-1:0]    i_raddr,
    output mrtl_pkg::t_entry      o_rdata
);

    mrtl_pkg::t_entry r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hdl/mrtl_walk.sv */
// ----------------------------------------------------------------------------
// Lookup walker
// Takes items, writes the table, walks it for lookups and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module mrtl_walk #(
    parameter int MAX_RANGES = 128,
    parameter int IW         = 7,
    parameter int CW         = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [mrtl_pkg::TYPE_W-1:0]   i_default_type,
    input  wire logic [mrtl_pkg::COUNT_W-1:0]  i_range_count,
    mrtl_in_if.sink                            i_in,
    mrtl_out_if.source                         o_out,
    output logic                               o_we,
    output logic [IW-1:0]                      o_waddr,
    output mrtl_pkg::t_entry                   o_wdata,
    output logic [IW-1:0]                      o_raddr,
    input  wire mrtl_pkg::t_entry              i_rdata
);

    localparam int PW = mrtl_pkg::PAGE_W;
    localparam int LW = mrtl_pkg::COUNT_W + 1;

    mrtl_pkg::t_state r_state, n_state;

    logic [PW-1:0]               r_lo, n_lo;
    logic [PW-1:0]               r_hi, n_hi;
    logic                        r_large, n_large;
    logic [mrtl_pkg::TYPE_W-1:0] r_type, n_type;
    logic                        r_stop, n_stop;
    logic                        r_fits, n_fits;
    logic [CW-1:0]               r_cnt, n_cnt;
    logic [CW-1:0]               r_limit, n_limit;
    logic                        r_out_valid, n_out_valid;
    logic [mrtl_pkg::TYPE_W-1:0] r_out_type, n_out_type;
    logic                        r_out_ok, n_out_ok;

    logic                        accept;
    logic                        out_free;
    logic [LW-1:0]               limit_full;
    logic [8:0]                  idx_ext;
    logic [CW-1:0]               cnt_inc;
    logic [PW-1:0]               page_lo;
    logic [PW-1:0]               page_hi;
    logic [PW-1:0]               e_base;
    logic [PW-1:0]               e_last;
    logic                        contain;
    logic                        split;

    // Input beats are taken only out of reset and while no lookup is running.
    assign i_in.ready = i_rst_n && (r_state == mrtl_pkg::ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    assign o_out.valid         = r_out_valid;
    assign o_out.resolved_type = r_out_type;
    assign o_out.large_page_ok = r_out_ok;

    // Table write straight from an accepted write beat.
    assign idx_ext       = 9'(i_in.entry_index);
    assign o_we          = accept && (i_in.op == mrtl_pkg::OP_WRITE)
                           && (int'(idx_ext) < MAX_RANGES);
    assign o_waddr       = idx_ext[IW-1:0];
    assign o_wdata.base  = i_in.range_base;
    assign o_wdata.last  = i_in.range_end;
    assign o_wdata.mtype = i_in.range_type;
    assign o_wdata.fixed = i_in.range_fixed;

    // Entries walked: the count register clipped to the table depth.
    assign limit_full = (LW'(i_range_count) > LW'(MAX_RANGES)) ?
                        LW'(MAX_RANGES) : LW'(i_range_count);

    // Page byte range; the low bits of the start are zero, so the end is an OR.
    always_comb begin
        if (i_in.page_is_large) begin
            page_lo = {i_in.page_number, {mrtl_pkg::LARGE_SHIFT{1'b0}}};
            page_hi = {i_in.page_number, {mrtl_pkg::LARGE_SHIFT{1'b1}}};
        end else begin
            page_lo = PW'({i_in.page_number, {mrtl_pkg::SMALL_SHIFT{1'b0}}});
            page_hi = PW'({i_in.page_number, {mrtl_pkg::SMALL_SHIFT{1'b1}}});
        end
    end

    // The entry read last cycle is the one at r_cnt; fetch the next one now.
    assign cnt_inc = r_cnt + CW'(1);
    assign o_raddr = (r_state == mrtl_pkg::ST_IDLE) ? '0 : cnt_inc[IW-1:0];

    // Containment and boundary tests on the entry in hand.
    assign e_base  = PW'(i_rdata.base);
    assign e_last  = PW'(i_rdata.last);
    assign contain = (r_lo >= e_base) && (r_hi <= e_last);
    assign split   = ((r_lo <= e_last) && (r_hi > e_last))
                     || ((r_lo < e_base) && (r_hi >= e_base));

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mrtl_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Walk and result registers.
    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_large    <= n_large;
        r_type     <= n_type;
        r_stop     <= n_stop;
        r_fits     <= n_fits;
        r_cnt      <= n_cnt;
        r_limit    <= n_limit;
        r_out_type <= n_out_type;
        r_out_ok   <= n_out_ok;
    end

    // Next state and walk updates.
    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_large     = r_large;
        n_type      = r_type;
        n_stop      = r_stop;
        n_fits      = r_fits;
        n_cnt       = r_cnt;
        n_limit     = r_limit;
        n_out_type  = r_out_type;
        n_out_ok    = r_out_ok;
        n_out_valid = r_out_valid && !o_out.ready;

        unique case (r_state)
            mrtl_pkg::ST_IDLE: begin
                if (accept && (i_in.op == mrtl_pkg::OP_LOOKUP)) begin
                    n_lo    = page_lo;
                    n_hi    = page_hi;
                    n_large = i_in.page_is_large;
                    n_type  = i_default_type;
                    n_stop  = 1'b0;
                    n_fits  = 1'b1;
                    n_cnt   = '0;
                    n_limit = limit_full[CW-1:0];
                    n_state = (limit_full == '0) ? mrtl_pkg::ST_DONE
                                                 : mrtl_pkg::ST_WALK;
                end
            end
            mrtl_pkg::ST_WALK: begin
                // Type resolution freezes after a fixed or uncacheable match.
                if (contain && !r_stop) begin
                    n_type = i_rdata.mtype;
                    if (i_rdata.fixed || (i_rdata.mtype == mrtl_pkg::TYPE_UC)) begin
                        n_stop = 1'b1;
                    end
                end
                if (split) begin
                    n_fits = 1'b0;
                end
                n_cnt = cnt_inc;
                if (cnt_inc == r_limit) begin
                    n_state = mrtl_pkg::ST_DONE;
                end
            end
            mrtl_pkg::ST_DONE: begin
                // Hold until the output register can take the result.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_type  = r_type;
                    n_out_ok    = r_large ? r_fits : 1'b1;
                    n_state     = mrtl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mrtl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/memory_range_type_lookup_core.sv */
// ----------------------------------------------------------------------------
// Memory range type lookup core
// Range table with a sequential walker that resolves page memory types.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries items. A write beat (op = write) stores one range entry in
//   the table; entries at or above MAX_RANGES are dropped. A lookup beat
//   (op = lookup) walks table entries 0 .. min(range_count, MAX_RANGES) - 1
//   and gives one beat on o_out with the resolved type and the large-page
//   flag. Write beats give no output beat.
//   A write beat goes straight into the table. A lookup is accepted, walks
//   one entry per cycle through the single read port of the table memory,
//   and then loads the result into the output register.
//   i_in.ready is high only out of reset and while no lookup is in progress.
//   The result sits in an output register; a new item is taken while it
//   waits, and a walk that finishes with the register still full holds until
//   it drains.
//   i_cfg_we writes default_type (index 0) or range_count (index 1); write
//   them only while the core is idle.
//   Reset clears both registers and the handshake state; table contents are
//   undefined until written, and no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_range_type_lookup_core #(
    parameter int MAX_RANGES = 128
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [mrtl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [mrtl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    mrtl_in_if.sink                                i_in,
    mrtl_out_if.source                             o_out
);

    localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);

    logic [mrtl_pkg::TYPE_W-1:0]  r_default_type;
    logic [mrtl_pkg::COUNT_W-1:0] r_range_count;

    logic             we;
    logic [IW-1:0]    waddr;
    logic [IW-1:0]    raddr;
    mrtl_pkg::t_entry wdata;
    mrtl_pkg::t_entry rdata;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_type <= '0;
            r_range_count  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mrtl_pkg::CFG_DEFAULT_TYPE: begin
                    r_default_type <= i_cfg_data[mrtl_pkg::TYPE_W-1:0];
                end
                mrtl_pkg::CFG_RANGE_COUNT: begin
                    r_range_count <= i_cfg_data[mrtl_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Range table storage.
    mrtl_table #(
        .DEPTH (MAX_RANGES),
        .IW    (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Item handling and table walk.
    mrtl_walk #(
        .MAX_RANGES (MAX_RANGES),
        .IW         (IW),
        .CW         (CW)
    ) u_walk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_default_type (r_default_type),
        .i_range_count  (r_range_count),
        .i_in           (i_in),
        .o_out          (o_out),
        .o_we           (we),
        .o_waddr        (waddr),
        .o_wdata        (wdata),
        .o_raddr        (raddr),
        .i_rdata        (rdata)
    );

endmodule

`default_nettype wire

/* test/tb_memory_range_type_lookup_core.sv */
// ----------------------------------------------------------------------------
// Memory range type lookup core testbench
// Loads range entries and looks up 4 KB and 2 MB pages against them. A
// scoreboard class keeps its own copy of the range table and registers,
// predicts the type and the large-page flag of every lookup, and compares
// each result beat with the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_memory_range_type_lookup_core;
    timeunit 1ns;
    timeprecision 1ps;

    // Field widths taken from the package.
    localparam int ADDR_W      = mrtl_pkg::ADDR_W;
    localparam int TYPE_W      = mrtl_pkg::TYPE_W;
    localparam int INDEX_W     = mrtl_pkg::INDEX_W;
    localparam int PFN_W       = mrtl_pkg::PFN_W;
    localparam int COUNT_W     = mrtl_pkg::COUNT_W;
    localparam int CFG_IDX_W   = mrtl_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = mrtl_pkg::CFG_DATA_W;
    localparam int SMALL_SHIFT = mrtl_pkg::SMALL_SHIFT;
    localparam int LARGE_SHIFT = mrtl_pkg::LARGE_SHIFT;

    localparam int TABLE_DEPTH   = 128;
    localparam int CLK_PERIOD    = 8;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RUN_LIMIT_NS  = 8_000_000;

    localparam bit [63:0] ADDR_TOP   = 64'h000F_FFFF_FFFF_FFFF;
    localparam bit [63:0] PAGE_4K    = 64'h1000;
    localparam bit [63:0] PAGE_2M    = 64'h20_0000;
    localparam bit [63:0] REGION_TOP = 64'h000F_FFFF_F800_0000;

    // One input beat, write and lookup fields together.
    typedef struct packed {
        bit                op;
        bit [INDEX_W-1:0]  index;
        bit [ADDR_W-1:0]   base_addr;
        bit [ADDR_W-1:0]   end_addr;
        bit [TYPE_W-1:0]   mtype;
        bit                fixed;
        bit [PFN_W-1:0]    pfn;
        bit                big_page;
    } t_range_item;

    // One lookup result.
    typedef struct packed {
        bit [TYPE_W-1:0] mtype;
        bit              fits;
    } t_page_result;

    // Scoreboard: private range table, registers and pending lookup results.
    class t_page_scoreboard;
        bit [ADDR_W-1:0]  base_tbl[TABLE_DEPTH];
        bit [ADDR_W-1:0]  end_tbl[TABLE_DEPTH];
        bit [TYPE_W-1:0]  type_tbl[TABLE_DEPTH];
        bit               fixed_tbl[TABLE_DEPTH];
        bit [TYPE_W-1:0]  default_mtype;
        bit [COUNT_W-1:0] range_count;
        t_page_result     awaited[$];
        int               mismatch_count;

        function void write_register(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
            if (idx == mrtl_pkg::CFG_DEFAULT_TYPE) begin
                default_mtype = data[TYPE_W-1:0];
            end else if (idx == mrtl_pkg::CFG_RANGE_COUNT) begin
                range_count = data[COUNT_W-1:0];
            end
        endfunction

        // Walk the table in index order; a fixed or uncacheable match ends
        // type resolution, while the boundary check covers every walked entry.
        function t_page_result resolve_page(bit [PFN_W-1:0] pfn, bit is_2m);
            t_page_result r;
            bit [63:0]    lo_addr;
            bit [63:0]    hi_addr;
            int           walked;
            bit           stopped;
            lo_addr = is_2m ? (64'(pfn) << LARGE_SHIFT) : (64'(pfn) << SMALL_SHIFT);
            hi_addr = lo_addr + (is_2m ? PAGE_2M : PAGE_4K) - 64'd1;
            walked  = (range_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(range_count);
            r.mtype = default_mtype;
            r.fits  = 1'b1;
            stopped = 1'b0;
            for (int i = 0; i < walked; i++) begin
                if (!stopped && lo_addr >= base_tbl[i] && hi_addr <= end_tbl[i]) begin
                    r.mtype = type_tbl[i];
                    stopped = fixed_tbl[i] || (type_tbl[i] == mrtl_pkg::TYPE_UC);
                end
                if (is_2m && lo_addr <= end_tbl[i] && hi_addr > end_tbl[i])
                    r.fits = 1'b0;
                if (is_2m && lo_addr < base_tbl[i] && hi_addr >= base_tbl[i])
                    r.fits = 1'b0;
            end
            return r;
        endfunction

        function void note_item(t_range_item it);
            if (it.op == mrtl_pkg::OP_WRITE) begin
                base_tbl[it.index]  = it.base_addr;
                end_tbl[it.index]   = it.end_addr;
                type_tbl[it.index]  = it.mtype;
                fixed_tbl[it.index] = it.fixed;
            end else begin
                awaited.push_back(resolve_page(it.pfn, it.big_page));
            end
        endfunction

        function void check_result(bit [TYPE_W-1:0] mtype, bit fits);
            t_page_result want;
            if (awaited.size() == 0) begin
                $error("resolved_type: expected none, actual %0d", mtype);
                mismatch_count++;
                return;
            end
            want = awaited.pop_front();
            if (mtype != want.mtype) begin
                $error("resolved_type: expected %0d, actual %0d", want.mtype, mtype);
                mismatch_count++;
            end
            if (fits != want.fits) begin
                $error("large_page_ok: expected %0d, actual %0d", want.fits, fits);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mrtl_in_if  in_ch ();
    mrtl_out_if out_ch ();

    memory_range_type_lookup_core #(
        .MAX_RANGES (TABLE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    t_page_scoreboard mtype_sb = new();

    bit               written[TABLE_DEPTH];
    bit [COUNT_W-1:0] cur_count;
    bit [63:0]        region;
    bit               calm;
    bit               sink_stalls;
    bit               source_gaps;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #(RUN_LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

    // Result side: random stall bursts while enabled.
    initial begin
        out_ch.ready <= 1'b1;
        @(posedge i_clk);
        forever begin
            if (sink_stalls && !calm && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Observe register writes and beats on both channels at each edge.
    always @(posedge i_clk) begin : watch
        t_range_item seen;
        if (i_rst_n) begin
            if (i_cfg_we)
                mtype_sb.write_register(i_cfg_idx, i_cfg_data);
            if (out_ch.valid && out_ch.ready)
                mtype_sb.check_result(out_ch.resolved_type, out_ch.large_page_ok);
            if (in_ch.valid && in_ch.ready) begin
                seen.op        = in_ch.op;
                seen.index     = in_ch.entry_index;
                seen.base_addr = in_ch.range_base;
                seen.end_addr  = in_ch.range_end;
                seen.mtype     = in_ch.range_type;
                seen.fixed     = in_ch.range_fixed;
                seen.pfn       = in_ch.page_number;
                seen.big_page  = in_ch.page_is_large;
                mtype_sb.note_item(seen);
            end
        end
    end

    function automatic int first_unwritten();
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!written[i])
                return i;
        end
        return TABLE_DEPTH;
    endfunction

    function automatic int walk_depth();
        return (cur_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(cur_count);
    endfunction

    // Every field random; callers then set the fields that matter.
    function automatic t_range_item random_noise();
        t_range_item it;
        it.op        = 1'($urandom_range(0, 1));
        it.index     = INDEX_W'($urandom);
        it.base_addr = ADDR_W'({$urandom, $urandom});
        it.end_addr  = ADDR_W'({$urandom, $urandom});
        it.mtype     = TYPE_W'($urandom);
        it.fixed     = 1'($urandom_range(0, 1));
        it.pfn       = PFN_W'({$urandom, $urandom});
        it.big_page  = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Slot for a write: mostly grow the written prefix or rewrite a walked slot.
    function automatic bit [INDEX_W-1:0] pick_slot();
        int prefix;
        int walked;
        int r;
        prefix = first_unwritten();
        walked = walk_depth();
        r      = $urandom_range(0, 9);
        if (prefix < TABLE_DEPTH && r < 4)
            return INDEX_W'(prefix);
        if (walked > 0 && r < 8)
            return INDEX_W'($urandom_range(0, walked - 1));
        return INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
    endfunction

    // Range mostly inside the current region, page or byte granular, sometimes inverted.
    function automatic t_range_item random_range(bit [INDEX_W-1:0] slot);
        t_range_item it;
        bit [63:0]   gran;
        bit [63:0]   lo;
        bit [63:0]   hi;
        int          sel;
        it       = random_noise();
        it.op    = mrtl_pkg::OP_WRITE;
        it.index = slot;
        it.fixed = ($urandom_range(0, 5) == 0);
        sel      = $urandom_range(0, 19);
        if (sel != 0) begin
            gran = (sel < 9) ? PAGE_4K : (sel < 19) ? PAGE_2M : 64'd1;
            lo   = region + (64'($urandom_range(0, 32'h3FF_FFFF)) / gran) * gran;
            hi   = lo + gran * 64'($urandom_range(1, (gran == PAGE_2M) ? 8 : 64)) - 64'd1;
            if ($urandom_range(0, 9) == 0)
                hi = lo - 64'($urandom_range(1, 32'h40_0000));
            if (hi > ADDR_TOP)
                hi = ADDR_TOP;
            it.base_addr = lo[ADDR_W-1:0];
            it.end_addr  = hi[ADDR_W-1:0];
        end
        return it;
    endfunction

    // Lookup aimed at the edges of a walked range, into the region, or anywhere.
    function automatic t_range_item random_lookup();
        t_range_item it;
        bit [63:0]   addr;
        int          walked;
        int          slot;
        int          pick;
        it       = random_noise();
        it.op    = mrtl_pkg::OP_LOOKUP;
        walked   = walk_depth();
        pick     = $urandom_range(0, 9);
        if (pick == 9)
            return it;
        if (walked > 0 && pick < 6) begin
            slot = $urandom_range(0, walked - 1);
            case ($urandom_range(0, 2))
                0: addr = 64'(mtype_sb.base_tbl[slot]);
                1: addr = 64'(mtype_sb.end_tbl[slot]);
                default: addr = 64'(mtype_sb.end_tbl[slot]) + 64'd1;
            endcase
            if ($urandom_range(0, 1) == 1)
                addr = addr + 64'($urandom_range(0, 32'h3F_FFFF)) - 64'h20_0000;
        end else begin
            addr = region + 64'($urandom_range(0, 32'h4FF_FFFF));
        end
        it.pfn = it.big_page ? addr[LARGE_SHIFT+PFN_W-1:LARGE_SHIFT]
                             : addr[SMALL_SHIFT+PFN_W-1:SMALL_SHIFT];
        return it;
    endfunction

    task automatic send_item(input t_range_item it);
        in_ch.valid         <= 1'b1;
        in_ch.op            <= it.op;
        in_ch.entry_index   <= it.index;
        in_ch.range_base    <= it.base_addr;
        in_ch.range_end     <= it.end_addr;
        in_ch.range_type    <= it.mtype;
        in_ch.range_fixed   <= it.fixed;
        in_ch.page_number   <= it.pfn;
        in_ch.page_is_large <= it.big_page;
        if (it.op == mrtl_pkg::OP_WRITE)
            written[it.index] = 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic idle_gap(input int cycles);
        in_ch.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Hold the sender until every lookup result is back and the walker is quiet.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (mtype_sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic put_range(input int slot, input bit [63:0] lo,
                             input bit [63:0] hi, input int mtype,
                             input bit fixed);
        t_range_item it;
        it           = random_noise();
        it.op        = mrtl_pkg::OP_WRITE;
        it.index     = INDEX_W'(slot);
        it.base_addr = lo[ADDR_W-1:0];
        it.end_addr  = hi[ADDR_W-1:0];
        it.mtype     = TYPE_W'(mtype);
        it.fixed     = fixed;
        send_item(it);
    endtask

    task automatic ask_page(input bit [63:0] pfn, input bit is_2m);
        t_range_item it;
        it          = random_noise();
        it.op       = mrtl_pkg::OP_LOOKUP;
        it.pfn      = pfn[PFN_W-1:0];
        it.big_page = is_2m;
        send_item(it);
    endtask

    // Directed cases: empty table, override order, uncacheable and fixed stops,
    // inverted range, the top of the address space and pages above it.
    task automatic run_directed();
        ask_page(64'h0, 1'b0);
        settle();
        set_register(mrtl_pkg::CFG_DEFAULT_TYPE, CFG_DATA_W'(7));
        ask_page(64'h0, 1'b0);
        ask_page('1, 1'b1);
        put_range(0, 64'h0, ADDR_TOP, 2, 1'b0);
        put_range(1, 64'h0, 64'h3F_FFFF, 6, 1'b0);
        put_range(2, 64'h20_0000, 64'h3F_FFFF, 4, 1'b0);
        put_range(3, 64'h1000, 64'h1FFF, int'(mrtl_pkg::TYPE_UC), 1'b0);
        put_range(4, 64'h5000, 64'h5FFF, 5, 1'b1);
        put_range(5, 64'h5000, 64'h5FFF, 1, 1'b0);
        put_range(6, 64'h90_0000, 64'h80_0000, 3, 1'b0);
        put_range(7, ADDR_TOP - 64'h1F_FFFF, ADDR_TOP, 7, 1'b1);
        settle();
        set_register(mrtl_pkg::CFG_DEFAULT_TYPE, CFG_DATA_W'(5));
        cur_count = COUNT_W'(8);
        set_register(mrtl_pkg::CFG_RANGE_COUNT, CFG_DATA_W'(cur_count));
        ask_page(64'h0, 1'b0);
        ask_page(64'h1, 1'b0);
        ask_page(64'h5, 1'b0);
        ask_page(64'h200, 1'b0);
        ask_page(64'h0, 1'b1);
        ask_page(64'h1, 1'b1);
        ask_page(64'h4, 1'b1);
        ask_page(64'h7FFF_FFFF, 1'b1);
        ask_page(64'h8000_0000, 1'b1);
        ask_page('1, 1'b0);
    endtask

    // Random phases; each starts idle with new register values and region.
    task automatic run_random();
        int sent;
        int n;
        int phase_len;
        int prefix;
        bit full_walk_done;
        sent           = 0;
        full_walk_done = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            prefix = first_unwritten();
            if (prefix == TABLE_DEPTH && !full_walk_done) begin
                cur_count      = '1;
                full_walk_done = 1'b1;
            end else if (prefix == TABLE_DEPTH && $urandom_range(0, 7) == 0) begin
                cur_count = COUNT_W'($urandom_range(TABLE_DEPTH, 255));
            end else if ($urandom_range(0, 9) < 2) begin
                cur_count = COUNT_W'(prefix);
            end else begin
                cur_count = COUNT_W'($urandom_range(0, (prefix < 12) ? prefix : 12));
            end
            set_register(mrtl_pkg::CFG_DEFAULT_TYPE, CFG_DATA_W'($urandom_range(0, 7)));
            set_register(mrtl_pkg::CFG_RANGE_COUNT, CFG_DATA_W'(cur_count));

            case ($urandom_range(0, 3))
                0: region = 64'h0;
                1: region = REGION_TOP;
                default: begin
                    region = {$urandom, $urandom} & 64'h000F_FFFF_FFE0_0000;
                    if (region > REGION_TOP)
                        region = REGION_TOP;
                end
            endcase

            // The tail of the run goes without any idling.
            calm        = (sent >= RANDOM_ITEMS * 17 / 20);
            sink_stalls = !calm && ($urandom_range(0, 3) != 0);
            source_gaps = !calm && ($urandom_range(0, 3) != 0);
            phase_len   = $urandom_range(15, 50);

            for (n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
                if ($urandom_range(0, 9) < 4)
                    send_item(random_range(pick_slot()));
                else
                    send_item(random_lookup());
                sent++;
                if (!calm && $urandom_range(0, 39) == 0)
                    settle();
                else if (source_gaps && $urandom_range(0, 3) == 0)
                    idle_gap($urandom_range(1, 7));
            end
        end
    endtask

    initial begin : stimulus
        int waited;
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= '0;
        i_cfg_data          <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.op            <= mrtl_pkg::OP_WRITE;
        in_ch.entry_index   <= '0;
        in_ch.range_base    <= '0;
        in_ch.range_end     <= '0;
        in_ch.range_type    <= '0;
        in_ch.range_fixed   <= 1'b0;
        in_ch.page_number   <= '0;
        in_ch.page_is_large <= 1'b0;
        calm        = 1'b0;
        sink_stalls = 1'b0;
        source_gaps = 1'b0;
        cur_count   = '0;
        region      = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_random();

        // Drain the remaining results, then let the walker go quiet.
        in_ch.valid <= 1'b0;
        waited = 0;
        @(posedge i_clk);
        while (mtype_sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mtype_sb.pending() != 0)
            $error("resolved_type: expected %0d more beats, actual none", mtype_sb.pending());

        if (mtype_sb.mismatch_count == 0 && mtype_sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
